[sv/ssms_pkg.sv]
// Package for the stock span block: transaction payload types, stack entry
// type, shift command struct, controller state enum and shared constants.
// No dependencies.
package ssms_pkg;

    // Default stack depth (number of cells in the chain)
    localparam int STACK_DEPTH_DEF = 64;

    localparam int PRICE_W = 32;
    localparam int DAY_W   = 32;

    // Saturated day value
    localparam logic [DAY_W-1:0] DAY_MAX = {DAY_W{1'b1}};

    // Input transaction payload
    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic                      first;
    } in_t;

    // Result transaction payload
    typedef struct packed {
        logic [DAY_W-1:0] span_days;
        logic             overflow;
    } out_t;

    // One stack entry held by a cell
    typedef struct packed {
        logic signed [PRICE_W-1:0] price;
        logic [DAY_W-1:0]          day;
    } entry_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic push;   // move every entry one cell down, load new top
        logic pop;    // move every entry one cell up, top falls out
    } shift_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

[sv/ssms_cell.sv]
// One cell of the stack chain: holds a single (price, day) entry and takes
// its neighbor's entry on a push or a pop. Depends on ssms_pkg.
module ssms_cell (
    input  logic                aclk,
    input  ssms_pkg::shift_t    shift,
    input  ssms_pkg::entry_t    above,
    input  ssms_pkg::entry_t    below,
    output ssms_pkg::entry_t    entry
);

    ssms_pkg::entry_t entry_reg;
    ssms_pkg::entry_t entry_next;

    // Push takes the entry from the cell above, pop from the cell below
    always_comb begin
        entry_next = entry_reg;
        if (shift.push) begin
            entry_next = above;
        end else if (shift.pop) begin
            entry_next = below;
        end
    end

    // Payload only, no reset needed
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[sv/ssms_ctrl.sv]
// Sequencer for the stock span block: accepts a transaction, pops the chain
// one entry per cycle, then pushes and registers the result.
// Depends on ssms_pkg.
module ssms_ctrl #(
    parameter int STACK_DEPTH = ssms_pkg::STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssms_pkg::in_t       s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssms_pkg::out_t      m_data,
    input  ssms_pkg::entry_t    top_entry,
    output ssms_pkg::entry_t    push_entry,
    output ssms_pkg::shift_t    shift
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    ssms_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [ssms_pkg::DAY_W-1:0] day_reg, day_next;
    ssms_pkg::entry_t item_reg, item_next;
    ssms_pkg::out_t   out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic [ssms_pkg::DAY_W-1:0] cur_day;
    logic                       top_pops;
    logic                       out_free;
    logic [ssms_pkg::DAY_W-1:0] span;

    assign cur_day  = s_data.first ? '0 : day_reg;
    assign top_pops = (count_reg != '0) && (top_entry.price <= item_reg.price);
    assign out_free = !m_valid_reg || m_ready;

    // Span against the current top of stack
    always_comb begin
        if (count_reg == '0) begin
            span = (item_reg.day == ssms_pkg::DAY_MAX) ? ssms_pkg::DAY_MAX
                                                       : item_reg.day + 1'b1;
        end else begin
            span = (item_reg.day > top_entry.day) ? item_reg.day - top_entry.day
                                                   : {{(ssms_pkg::DAY_W-1){1'b0}}, 1'b1};
        end
    end

    // Next state and outputs
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        day_next     = day_reg;
        item_next    = item_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        shift        = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ssms_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next.price = s_data.price;
                    item_next.day   = cur_day;
                    day_next        = (cur_day == ssms_pkg::DAY_MAX) ? ssms_pkg::DAY_MAX
                                                                     : cur_day + 1'b1;
                    if (s_data.first) begin
                        count_next = '0;
                    end
                    state_next = ssms_pkg::ST_WALK;
                end
            end
            ssms_pkg::ST_WALK: begin
                if (top_pops) begin
                    shift.pop  = 1'b1;
                    count_next = count_reg - 1'b1;
                end else if (out_free) begin
                    // Push; a full chain drops its bottom cell
                    shift.push         = 1'b1;
                    out_next.span_days = span;
                    out_next.overflow  = (count_reg == FULL);
                    if (count_reg != FULL) begin
                        count_next = count_reg + 1'b1;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ssms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssms_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssms_pkg::ST_IDLE;
            count_reg   <= '0;
            day_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            day_reg     <= day_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign push_entry = item_reg;
    assign m_valid    = m_valid_reg;
    assign m_data     = out_reg;

endmodule

[sv/stock_span_monotonic_stack.sv]
// Top level of the stock span block: sequencer plus a chain of stack cells.
// Depends on ssms_pkg, ssms_cell and ssms_ctrl.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | s_data: price, first
//  m_      | out       | m_valid / m_ready  | m_data: span_days, overflow
//
// An item is handled in order: an accept in ST_IDLE, one pop of the cell
// chain per cycle for each entry it pops, then a push.
// Reset (aresetn low, synchronous) empties the stack and zeroes the day count.
// A result waits in the output register; the next transaction is accepted
// meanwhile, and its push cycle holds until that register is free.
module stock_span_monotonic_stack #(
    parameter int STACK_DEPTH = ssms_pkg::STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssms_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssms_pkg::out_t    m_data
);

    ssms_pkg::entry_t cell_q [STACK_DEPTH];
    ssms_pkg::entry_t push_entry;
    ssms_pkg::shift_t shift;

    ssms_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .top_entry  (cell_q[0]),
        .push_entry (push_entry),
        .shift      (shift)
    );

    // Cell 0 is the top of stack; the last cell is the bottom
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        ssms_pkg::entry_t above;
        ssms_pkg::entry_t below;

        if (i == 0) begin : g_top
            assign above = push_entry;
        end else begin : g_mid_a
            assign above = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_bot
            assign below = '0;
        end else begin : g_mid_b
            assign below = cell_q[i+1];
        end

        ssms_cell u_cell (
            .aclk  (aclk),
            .shift (shift),
            .above (above),
            .below (below),
            .entry (cell_q[i])
        );
    end

endmodule

[tb/ssms_span_checker.sv]
`timescale 1ns / 1ps
// Span checker: watches both channels of the stock span block, predicts each span
// with its own monotonic stack and compares every result. Depends on ssms_pkg.
module ssms_span_checker #(
    parameter int DEPTH = ssms_pkg::STACK_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  ssms_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  ssms_pkg::out_t m_data,
    output int             span_errors,
    output int             spans_owed
);

    // Shadow stack, bottom at index 0
    logic signed [ssms_pkg::PRICE_W-1:0] shadow_price [DEPTH];
    logic [ssms_pkg::DAY_W-1:0]          shadow_day   [DEPTH];
    int                                  shadow_n = 0;
    logic [ssms_pkg::DAY_W-1:0]          day_next = '0;

    ssms_pkg::out_t span_queue [$];
    int             n_err = 0;

    assign span_errors = n_err;
    assign spans_owed  = span_queue.size();

    // Append one predicted result at the tail
    function automatic void queue_span(ssms_pkg::out_t r);
        span_queue.insert(span_queue.size(), r);
    endfunction

    // Span and overflow flag for one price; advances the shadow stack
    function automatic ssms_pkg::out_t span_for(ssms_pkg::in_t t);
        logic signed [ssms_pkg::PRICE_W-1:0] p;
        logic [ssms_pkg::DAY_W-1:0]          d;
        ssms_pkg::out_t                      r;
        p = t.price;
        if (t.first) begin
            shadow_n = 0;
            day_next = '0;
        end
        d = day_next;
        r.overflow = 1'b0;

        // drop every entry priced at or below today
        while (shadow_n > 0 && $signed(shadow_price[shadow_n-1]) <= $signed(p))
            shadow_n--;

        if (shadow_n == 0)
            r.span_days = (d == ssms_pkg::DAY_MAX) ? ssms_pkg::DAY_MAX : d + 1'b1;
        else if (d > shadow_day[shadow_n-1])
            r.span_days = d - shadow_day[shadow_n-1];
        else
            r.span_days = 1;

        // full stack: oldest entry falls off the bottom
        if (shadow_n == DEPTH) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                shadow_price[i] = shadow_price[i+1];
                shadow_day[i]   = shadow_day[i+1];
            end
            shadow_n   = DEPTH - 1;
            r.overflow = 1'b1;
        end
        shadow_price[shadow_n] = p;
        shadow_day[shadow_n]   = d;
        shadow_n++;

        if (day_next != ssms_pkg::DAY_MAX)
            day_next = day_next + 1'b1;
        return r;
    endfunction

    // Result side first: a span can never leave in the cycle its price arrives
    always @(posedge aclk) begin
        ssms_pkg::out_t want;
        if (!aresetn) begin
            shadow_n = 0;
            day_next = '0;
            span_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (span_queue.size() == 0) begin
                    if (n_err < 10)
                        $display("unexpected result: span %0d ovf %0b",
                                 m_data.span_days, m_data.overflow);
                    n_err++;
                end else begin
                    want = span_queue.pop_front();
                    if (m_data.span_days !== want.span_days ||
                        m_data.overflow !== want.overflow) begin
                        if (n_err < 10)
                            $display({"span mismatch: expected span %0d ovf %0b,",
                                      " got span %0d ovf %0b"},
                                     want.span_days, want.overflow,
                                     m_data.span_days, m_data.overflow);
                        n_err++;
                    end
                end
            end
            if (s_valid && s_ready)
                queue_span(span_for(s_data));
        end
    end

endmodule

[tb/stock_span_monotonic_stack_test.sv]
`timescale 1ns / 1ps
// Top of the stock span testbench: clock, reset, price stimulus and result back-pressure.
// Depends on ssms_pkg, stock_span_monotonic_stack and ssms_span_checker.
module stock_span_monotonic_stack_test;

    localparam int N_ITEMS = 1950;

    typedef enum {
        RUN_SCATTER,   // full-range prices
        RUN_CLUSTER,   // narrow band, many ties
        RUN_FALL,      // descending run, often long enough to overflow the stack
        RUN_RISE,      // ascending run, each price pops the price before it
        RUN_ZIGZAG
    } run_kind_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    ssms_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    ssms_pkg::out_t m_data;

    int span_errors;
    int spans_owed;
    int sent   = 0;
    bit steady = 1'b0;

    always #1 aclk = ~aclk;

    stock_span_monotonic_stack dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ssms_span_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .span_errors (span_errors),
        .spans_owed  (spans_owed)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one price transaction at a falling edge, hold until taken, then maybe idle
    task automatic push_price(input logic signed [ssms_pkg::PRICE_W-1:0] p, input logic f);
        int gap;
        s_valid      <= 1'b1;
        s_data.price <= p;
        s_data.first <= f;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
        @(negedge aclk);
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Result back-pressure; every so often a long hold-off fills the block
    initial begin
        int stall;
        wait (aresetn);
        @(negedge aclk);
        for (int round = 0; ; round++) begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            stall = (round % 60 == 30) ? 400 : idle_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Reset and price stimulus
    initial begin
        run_kind_t kind;
        int        len;
        int        cur;
        int        base;
        logic      f;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, ties, restart, textbook sequence
        push_price(0, 1'b0);                     // no restart after reset
        push_price(32'sh8000_0000, 1'b0);
        push_price(32'sh7fff_ffff, 1'b0);        // pops to empty
        push_price(32'sh7fff_ffff, 1'b0);        // tie pops too
        push_price(-1, 1'b0);
        push_price(0, 1'b1);
        push_price(100, 1'b1);
        push_price(80, 1'b0);
        push_price(60, 1'b0);
        push_price(70, 1'b0);
        push_price(60, 1'b0);
        push_price(75, 1'b0);
        push_price(85, 1'b0);
        push_price(5, 1'b1);
        push_price(5, 1'b0);
        push_price(5, 1'b0);
        push_price(32'sh5555_5555, 1'b0);
        push_price(32'shAAAA_AAAA, 1'b0);
        push_price(32'sh8000_0000, 1'b1);

        // Random series; day-count saturation needs 2^32 - 1 days and is out of reach
        while (sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1:    kind = RUN_SCATTER;
                2, 3:    kind = RUN_CLUSTER;
                4, 5, 6: kind = RUN_FALL;
                7:       kind = RUN_RISE;
                default: kind = RUN_ZIGZAG;
            endcase
            len    = (kind == RUN_FALL) ? $urandom_range(40, 100) : $urandom_range(1, 60);
            steady = ($urandom_range(0, 3) == 0);
            cur    = int'($urandom_range(0, 2000000000)) - 1000000000;
            base   = $urandom;
            for (int k = 0; k < len && sent < N_ITEMS; k++) begin
                case (kind)
                    RUN_SCATTER: cur = $urandom;
                    RUN_CLUSTER: cur = base + int'($urandom_range(0, 6)) - 3;
                    RUN_FALL:
                        cur = cur - (($urandom_range(0, 7) == 0) ? 0 :
                                     int'($urandom_range(1, 3)));
                    RUN_RISE:    cur = cur + int'($urandom_range(0, 1000));
                    default:
                        cur = (k % 2) ? cur - int'($urandom_range(1, 500))
                                      : cur + int'($urandom_range(0, 400));
                endcase
                // a high close after a long fall empties an overflowed stack
                if (kind == RUN_FALL && k == len - 1 && $urandom_range(0, 1))
                    cur = 32'sh7fff_ffff;
                if ($urandom_range(0, 49) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       cur = 32'sh8000_0000;
                        1:       cur = 32'sh7fff_ffff;
                        2:       cur = 0;
                        default: cur = -1;
                    endcase
                end
                // series mostly open with a restart; a few continue or restart midway
                if (k == 0)
                    f = ($urandom_range(0, 99) < 85);
                else
                    f = ($urandom_range(0, 99) < 3);
                push_price(cur, f);
            end
        end

        s_valid <= 1'b0;
        wait (spans_owed == 0);
        repeat (100) @(posedge aclk);
        if (span_errors == 0 && spans_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
